// ===== hw/rtl/skvt_pkg.sv =====
// Shared constants and types for the sorted key/value table.
package skvt_pkg;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned KeyBits   = 32;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned CntW      = $clog2(Capacity + 1);
  localparam int unsigned PosW      = 7;

  typedef enum logic [1:0] {
    ACT_FIND   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_e;

  // Broadcast from the controller to every cell in the update cycle.
  typedef struct packed {
    logic                 ins;
    logic                 rem;
    logic                 upd;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
  } cell_ctl_t;

  // Compare flags a cell reports back to the controller.
  typedef struct packed {
    logic lt;
    logic bnd;
    logic hit;
  } cell_stat_t;

endpackage

// ===== hw/rtl/skvt_cell.sv =====
// One entry of the table: key, value and compare flags, with neighbor shift paths.
module skvt_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [skvt_pkg::CntW-1:0]     idx_i,
  input  logic [skvt_pkg::CntW-1:0]     count_i,
  input  logic                          cmp_en_i,
  input  logic [skvt_pkg::KeyBits-1:0]  cmp_key_i,
  input  skvt_pkg::cell_ctl_t           ctl_i,
  input  logic                          prev_lt_i,
  input  logic [skvt_pkg::KeyBits-1:0]  left_key_i,
  input  logic [skvt_pkg::ValueBits-1:0] left_val_i,
  input  logic [skvt_pkg::KeyBits-1:0]  right_key_i,
  input  logic [skvt_pkg::ValueBits-1:0] right_val_i,
  output logic [skvt_pkg::KeyBits-1:0]  key_o,
  output logic [skvt_pkg::ValueBits-1:0] val_o,
  output skvt_pkg::cell_stat_t          stat_o
);
  import skvt_pkg::*;

  logic [KeyBits-1:0]   key_q, key_d;
  logic [ValueBits-1:0] val_q, val_d;
  logic                 lt_q, lt_d;
  logic                 eq_q, eq_d;
  logic                 occ;
  logic                 bnd;

  assign occ = (idx_i < count_i);
  assign lt_d = occ && (key_q < cmp_key_i);
  assign eq_d = occ && (key_q == cmp_key_i);

  // First cell whose key is not below the search key.
  assign bnd = prev_lt_i & ~lt_q;

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    if (ctl_i.ins) begin
      if (!prev_lt_i) begin
        key_d = left_key_i;
        val_d = left_val_i;
      end else if (bnd) begin
        key_d = ctl_i.key;
        val_d = ctl_i.value;
      end
    end else if (ctl_i.rem) begin
      if (!lt_q) begin
        key_d = right_key_i;
        val_d = right_val_i;
      end
    end else if (ctl_i.upd) begin
      if (bnd && eq_q) begin
        val_d = ctl_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (cmp_en_i) begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  assign key_o      = key_q;
  assign val_o      = val_q;
  assign stat_o.lt  = lt_q;
  assign stat_o.bnd = bnd;
  assign stat_o.hit = bnd & eq_q;

endmodule

// ===== hw/rtl/sorted_key_value_table.sv =====
// Top level of the sorted key/value table: request control and the row of cells.
//
// Sorted table of up to 64 key/value entries, one cell per entry, kept in
// ascending unsigned key order. On acceptance of a request (find, add or
// update, remove) every cell compares its key with the request key; in the
// update state the controller picks the boundary cell and, on an insert or
// remove, the cells from it on shift one place away from or toward it at
// once. A new request is accepted in the cycle after the update. The update
// waits while an earlier result is held on the output; the result register
// frees the input side otherwise. An add of a new key to a full table is
// rejected with full_res set and the table left as it was. No clearing pass
// is needed after reset; the entry count alone marks which cells are live.
module sorted_key_value_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // key[31:0], value[63:32]
  input  logic [1:0]  s_axis_tuser_i,  // action[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // position[6:0], value_out[38:7],
                                       // entry_total[45:39], zero[47:46]
  output logic [3:0]  m_axis_tuser_o   // found[0], was_added[1], removed[2],
                                       // full_res[3]
);
  import skvt_pkg::*;

  state_e state_q, state_d;

  logic [1:0]           act_q;
  logic [KeyBits-1:0]   key_q;
  logic [ValueBits-1:0] val_q;
  logic [CntW-1:0]      count_q, count_d;

  logic                 out_valid_q, out_valid_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [ValueBits-1:0] vout_q, vout_d;
  logic [CntW-1:0]      total_q, total_d;
  logic                 found_q, found_d;
  logic                 added_q, added_d;
  logic                 removed_q, removed_d;
  logic                 full_q, full_d;

  logic                 accept;
  logic                 advance;
  logic                 hit;
  logic [CntW-1:0]      pos_c;
  logic [ValueBits-1:0] hit_val;
  logic                 is_add, is_rem;
  logic                 do_ins, do_rem;
  cell_ctl_t            ctl;

  logic [KeyBits-1:0]   cell_key [Capacity];
  logic [ValueBits-1:0] cell_val [Capacity];
  cell_stat_t           cell_stat [Capacity];

  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign advance = (state_q == ST_UPDATE) && (!out_valid_q || m_axis_tready_i);

  // Gather boundary position and hit value across the row.
  always_comb begin
    hit     = 1'b0;
    pos_c   = '0;
    hit_val = '0;
    for (int i = 0; i < Capacity; i++) begin
      hit     = hit | cell_stat[i].hit;
      pos_c   = pos_c | ({CntW{cell_stat[i].bnd}} & CntW'(i));
      hit_val = hit_val | ({ValueBits{cell_stat[i].hit}} & cell_val[i]);
    end
    // All live keys below the request key and no free cell left.
    if (cell_stat[Capacity-1].lt) begin
      pos_c = CntW'(Capacity);
    end
  end

  assign is_add = (act_q == ACT_ADD);
  assign is_rem = (act_q == ACT_REMOVE);
  assign do_ins = is_add && !hit && (count_q < CntW'(Capacity));
  assign do_rem = is_rem && hit;

  assign ctl.ins   = advance && do_ins;
  assign ctl.rem   = advance && do_rem;
  assign ctl.upd   = advance && is_add && hit;
  assign ctl.key   = key_q;
  assign ctl.value = val_q;

  always_comb begin
    count_d = count_q;
    if (ctl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctl.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (advance) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE:   s_axis_tready_o = 1'b1;
      ST_UPDATE: s_axis_tready_o = 1'b0;
      default:   s_axis_tready_o = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    vout_d      = vout_q;
    total_d     = total_q;
    found_d     = found_q;
    added_d     = added_q;
    removed_d   = removed_q;
    full_d      = full_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      pos_d       = PosW'(pos_c);
      total_d     = count_d;
      found_d     = hit;
      added_d     = do_ins;
      removed_d   = do_rem;
      full_d      = is_add && !hit && !do_ins;
      if (is_add) begin
        vout_d = (hit || do_ins) ? val_q : '0;
      end else begin
        vout_d = hit ? hit_val : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= s_axis_tuser_i;
      key_q <= s_axis_tdata_i[KeyBits-1:0];
      val_q <= s_axis_tdata_i[KeyBits +: ValueBits];
    end
    pos_q     <= pos_d;
    vout_q    <= vout_d;
    total_q   <= total_d;
    found_q   <= found_d;
    added_q   <= added_d;
    removed_q <= removed_d;
    full_q    <= full_d;
  end

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic                 prev_lt;
    logic [KeyBits-1:0]   left_key, right_key;
    logic [ValueBits-1:0] left_val, right_val;

    if (g == 0) begin : g_first
      assign prev_lt  = 1'b1;
      assign left_key = '0;
      assign left_val = '0;
    end else begin : g_mid
      assign prev_lt  = cell_stat[g-1].lt;
      assign left_key = cell_key[g-1];
      assign left_val = cell_val[g-1];
    end

    if (g == Capacity - 1) begin : g_last
      assign right_key = '0;
      assign right_val = '0;
    end else begin : g_inner
      assign right_key = cell_key[g+1];
      assign right_val = cell_val[g+1];
    end

    skvt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (CntW'(g)),
      .count_i     (count_q),
      .cmp_en_i    (accept),
      .cmp_key_i   (s_axis_tdata_i[KeyBits-1:0]),
      .ctl_i       (ctl),
      .prev_lt_i   (prev_lt),
      .left_key_i  (left_key),
      .left_val_i  (left_val),
      .right_key_i (right_key),
      .right_val_i (right_val),
      .key_o       (cell_key[g]),
      .val_o       (cell_val[g]),
      .stat_o      (cell_stat[g])
    );
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, total_q, vout_q, pos_q};
  assign m_axis_tuser_o  = {full_q, removed_q, added_q, found_q};

endmodule

// ===== hw/rtl/skvt_checker.sv =====
// Port-level checks for the sorted key/value table, bound to the top level.
module skvt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [63:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic [3:0]  m_axis_tuser_o
);
  import skvt_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // A new entry never coincides with a hit or a full rejection.
  a_add_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> !m_axis_tuser_o[0] && !m_axis_tuser_o[3])
    else $error("insert flagged together with hit or full");

  // Only a present key can be removed.
  a_rem_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2] |-> m_axis_tuser_o[0])
    else $error("remove reported without a hit");

  // A full rejection leaves the table at capacity.
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[3] |->
      m_axis_tdata_o[45:39] == CntW'(Capacity) && !m_axis_tuser_o[0])
    else $error("full reported below capacity");

endmodule

bind sorted_key_value_table skvt_checker u_skvt_checker (.*);

// ===== dv/tb_top.sv =====
// Testbench for the sorted key/value table: directed and random requests checked against a shadow table.
`timescale 1ns / 1ps

module tb_top;
  import skvt_pkg::*;

  // Unused action code, handled by the block like a find.
  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic        found;
    logic        was_added;
    logic        removed;
    logic        full_res;
    logic [6:0]  position;
    logic [31:0] value_out;
    logic [6:0]  entry_total;
  } lookup_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;  // key[31:0], value[63:32]
  logic [1:0]  s_axis_tuser_i = '0;  // action[1:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;  // position[6:0], value_out[38:7], entry_total[45:39], zero[47:46]
  logic [3:0]  m_axis_tuser_o;  // found[0], was_added[1], removed[2], full_res[3]

  // Shadow copy of the table contents.
  logic [31:0] shadow_keys [Capacity];
  logic [31:0] shadow_vals [Capacity];
  int unsigned shadow_count = 0;

  lookup_result_t pending_results [$];
  int unsigned    mismatch_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;

  sorted_key_value_table u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Lower-bound search over the live entries, then apply the request to the shadow table.
  function automatic lookup_result_t apply_table_op(logic [1:0] act, logic [31:0] key,
                                                    logic [31:0] value);
    lookup_result_t res;
    int unsigned    lo, hi, mid;
    logic           hit;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < shadow_count) && (shadow_keys[lo] == key);
    res = '0;
    res.found = hit;
    res.position = lo[6:0];
    res.value_out = hit ? shadow_vals[lo] : '0;
    if (act == ACT_ADD) begin
      if (hit) begin
        shadow_vals[lo] = value;
        res.value_out = value;
      end else if (shadow_count < Capacity) begin
        for (int i = int'(shadow_count); i > int'(lo); i--) begin
          shadow_keys[i] = shadow_keys[i-1];
          shadow_vals[i] = shadow_vals[i-1];
        end
        shadow_keys[lo] = key;
        shadow_vals[lo] = value;
        shadow_count++;
        res.value_out = value;
        res.was_added = 1'b1;
      end else begin
        // table full: reject the new key, leave everything as it is
        res.full_res = 1'b1;
        res.value_out = '0;
      end
    end else if (act == ACT_REMOVE && hit) begin
      for (int i = int'(lo); i < int'(shadow_count) - 1; i++) begin
        shadow_keys[i] = shadow_keys[i+1];
        shadow_vals[i] = shadow_vals[i+1];
      end
      shadow_count--;
      res.removed = 1'b1;
    end
    res.entry_total = shadow_count[6:0];
    return res;
  endfunction

  // Mostly keys near the live entries so that hits, neighbors and edges all show up.
  function automatic logic [31:0] pick_key();
    int unsigned sel;
    logic [31:0] base;
    sel = $urandom_range(99);
    if (shadow_count != 0) base = shadow_keys[$urandom_range(shadow_count - 1)];
    else base = $urandom;
    if (sel < 55 && shadow_count != 0) return base;
    if (sel < 65) return $urandom_range(1) ? base + 32'd1 : base - 32'd1;
    if (sel < 75) return 32'($urandom_range(31));
    if (sel < 85) return 32'hFFFF_FFFF - 32'($urandom_range(31));
    return $urandom;
  endfunction

  // Returns at the rising edge of the transfer with tvalid still high.
  task automatic send_request(logic [1:0] act, logic [31:0] key, logic [31:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {value, key};
    s_axis_tuser_i = act;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(apply_table_op(act, key, value));
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
  endtask

  task automatic test_directed();
    // empty table: find, remove and the unused code all miss at position 0
    send_request(ACT_FIND, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ACT_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // extreme keys and values
    send_request(ACT_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ACT_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ACT_ADD, 32'h8000_0000, 32'hA5A5_A5A5);
    send_request(ACT_ADD, 32'h7FFF_FFFF, 32'h1234_5678);
    send_request(ACT_FIND, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ACT_FIND, 32'h7FFF_FFFE, 32'h0000_0000);
    // update of a present key
    send_request(ACT_ADD, 32'h0000_0000, 32'h5A5A_5A5A);
    send_request(ACT_RESERVED, 32'h8000_0000, 32'h0000_0000);
    // remove present, then the same key again, now absent
    send_request(ACT_REMOVE, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(ACT_REMOVE, 32'h8000_0000, 32'h0000_0000);
    send_request(ACT_FIND, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ACT_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(ACT_FIND, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_full_table();
    logic [31:0] key;
    while (shadow_count < Capacity) send_request(ACT_ADD, pick_key(), $urandom);
    // new keys are rejected, present keys still update
    send_request(ACT_ADD, 32'h0000_0000, $urandom);
    send_request(ACT_ADD, 32'hFFFF_FFFF, $urandom);
    repeat (6) begin
      send_request(ACT_ADD, shadow_keys[$urandom_range(Capacity - 1)], $urandom);
      send_request(ACT_ADD, $urandom, $urandom);
      send_request(ACT_FIND, pick_key(), $urandom);
    end
    send_request(ACT_REMOVE, shadow_keys[$urandom_range(Capacity - 1)], $urandom);
    send_request(ACT_ADD, $urandom, $urandom);
    send_request(ACT_ADD, $urandom, $urandom);
    // drain the table again
    while (shadow_count != 0) begin
      key = shadow_keys[$urandom_range(shadow_count - 1)];
      send_request(ACT_REMOVE, key, $urandom);
      if ($urandom_range(3) == 0) send_request(ACT_FIND, pick_key(), $urandom);
    end
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned sel;
    logic [1:0]  act;
    repeat (n_items) begin
      sel = $urandom_range(99);
      if (sel < 40) act = ACT_ADD;
      else if (sel < 70) act = ACT_REMOVE;
      else if (sel < 95) act = ACT_FIND;
      else act = ACT_RESERVED;
      send_request(act, pick_key(), $urandom);
    end
  endtask

  // Receiver: stall at random at the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    lookup_result_t got;
    lookup_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.found       = m_axis_tuser_o[0];
      got.was_added   = m_axis_tuser_o[1];
      got.removed     = m_axis_tuser_o[2];
      got.full_res    = m_axis_tuser_o[3];
      got.position    = m_axis_tdata_o[6:0];
      got.value_out   = m_axis_tdata_o[38:7];
      got.entry_total = m_axis_tdata_o[45:39];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("%0t: result with nothing expected: pos=%0d val=%h total=%0d",
                   $realtime, got.position, got.value_out, got.entry_total);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_axis_tdata_o[47:46] !== 2'b00) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("%0t: mismatch exp found=%0b pos=%0d val=%h add=%0b rem=%0b full=%0b tot=%0d",
                     $realtime, want.found, want.position, want.value_out, want.was_added,
                     want.removed, want.full_res, want.entry_total);
            $display("%0t:          got found=%0b pos=%0d val=%h add=%0b rem=%0b full=%0b tot=%0d pad=%b",
                     $realtime, got.found, got.position, got.value_out, got.was_added,
                     got.removed, got.full_res, got.entry_total, m_axis_tdata_o[47:46]);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_idling(0, 0);
    test_directed();
    wait_all_results();

    set_idling(6, 6);
    test_full_table();
    wait_all_results();

    set_idling(0, 0);
    test_random_traffic(160);
    wait_all_results();
    set_idling(61, 0);
    test_random_traffic(160);
    wait_all_results();
    set_idling(0, 61);
    test_random_traffic(160);
    wait_all_results();
    set_idling(6, 6);
    test_random_traffic(160);
    wait_all_results();

    // catch any late or extra result
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sorted_key_value_table.f =====
hw/rtl/skvt_pkg.sv
hw/rtl/skvt_cell.sv
hw/rtl/sorted_key_value_table.sv
hw/rtl/skvt_checker.sv
dv/tb_top.sv
